### rtl/rdb_pkg.sv
// Shared definitions for the recursive-doubling barrier engine:
// phase codes, node roles, configuration register indexes and field widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rdb_pkg;

  // Field widths of the channels and registers
  localparam int unsigned PHASE_W    = 3;
  localparam int unsigned CFG_RANK_W = 10;
  localparam int unsigned ROLE_W     = 2;
  localparam int unsigned ROUND_W    = 4;
  localparam int unsigned FLAG_W     = 5;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned WORD_W     = 32;

  // Defaults for the top-level parameters
  localparam int unsigned DEF_RANK_BITS = 10;
  localparam int unsigned DEF_SEQ_BITS  = 32;

  // Phase codes
  localparam logic [PHASE_W-1:0] PH_INACTIVE = 3'd0;
  localparam logic [PHASE_W-1:0] PH_PRE      = 3'd1;
  localparam logic [PHASE_W-1:0] PH_EXCH     = 3'd2;
  localparam logic [PHASE_W-1:0] PH_POST     = 3'd3;
  localparam logic [PHASE_W-1:0] PH_DONE     = 3'd4;

  // Node roles
  localparam logic [ROLE_W-1:0] ROLE_EXCH_EXTRA = 2'd1;
  localparam logic [ROLE_W-1:0] ROLE_EXTRA      = 2'd2;

  // Input item kinds
  localparam logic KIND_START  = 1'b0;

  // Flag value that marks arrival (-1)
  localparam logic [FLAG_W-1:0] FLAG_ARRIVED = 5'h1f;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MY_RANK        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NODE_ROLE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXTRA_RANK     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXCHANGE_COUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FINAL_FLAG     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_POLL_LIMIT     = 3'd5;

endpackage

`default_nettype wire

### rtl/recursive_doubling_barrier_engine.sv
// Per-node recursive-doubling barrier engine: phase control, polling and yield.
// Depends on rdb_pkg.
//
// Usage:
//   The input channel (in_valid/in_ready) carries start items (in_kind 0,
//   with in_generation) and partner status responses (in_kind 1, with
//   in_partner_seq and in_partner_flag). Every accepted item yields exactly
//   one result on the output channel (out_valid/out_ready): the phase, the
//   rank to poll next, the published flag and sequence, done and yielded.
//   The cfg_ port writes one register per cycle with no handshake; write it
//   only while no item is in flight.
//   out_valid rises in the cycle after the input transfer. Throughput is one
//   item per cycle: the state update and the next result are computed in one
//   pass of logic from the accepted item into the result register.
//   in_ready is high while the result register is empty or is being drained
//   in the same cycle; a stalled receiver holds the result and stops input.
//   Synchronous reset clears the configuration (poll limit to 1), returns
//   the engine to the inactive phase and empties the result register.
`timescale 1ns / 1ps
`default_nettype none

module recursive_doubling_barrier_engine
  import rdb_pkg::*;
#(
  parameter int unsigned RANK_BITS = DEF_RANK_BITS,
  parameter int unsigned SEQ_BITS  = DEF_SEQ_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,

  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_kind,
  input  wire logic [WORD_W-1:0]     in_generation,
  input  wire logic [WORD_W-1:0]     in_partner_seq,
  input  wire logic signed [FLAG_W-1:0] in_partner_flag,

  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [PHASE_W-1:0]         out_phase,
  output logic [RANK_BITS-1:0]       out_poll_rank,
  output logic signed [FLAG_W-1:0]   out_my_flag,
  output logic [WORD_W-1:0]          out_my_seq,
  output logic                       out_done_res,
  output logic                       out_yielded
);

  localparam int unsigned RW = (RANK_BITS > CFG_RANK_W) ? RANK_BITS : CFG_RANK_W;
  localparam int unsigned SW = (SEQ_BITS > WORD_W) ? SEQ_BITS : WORD_W;

  // Configuration registers
  logic [CFG_RANK_W-1:0] my_rank_r;
  logic [ROLE_W-1:0]     node_role_r;
  logic [CFG_RANK_W-1:0] extra_rank_r;
  logic [ROUND_W-1:0]    exch_count_r;
  logic [ROUND_W-1:0]    final_flag_r;
  logic [COUNT_W-1:0]    poll_limit_r;

  // Engine state
  logic [PHASE_W-1:0]    phase_r,  phase_nxt;
  logic [ROUND_W-1:0]    round_r,  round_nxt;
  logic [SEQ_BITS-1:0]   gen_r,    gen_nxt;
  logic [FLAG_W-1:0]     flag_r,   flag_nxt;
  logic [COUNT_W-1:0]    cnt_r,    cnt_nxt;
  logic                  yield_nxt;

  // Result register
  logic                  out_valid_r;
  logic [PHASE_W-1:0]    out_phase_r;
  logic [RANK_BITS-1:0]  out_rank_r, rank_nxt;
  logic [FLAG_W-1:0]     out_flag_r;
  logic [WORD_W-1:0]     out_seq_r;
  logic                  out_done_r;
  logic                  out_yield_r;

  logic                  in_fire;
  logic [SW-1:0]         gen_ext, pseq_ext, gen_out_ext;
  logic [SEQ_BITS-1:0]   in_gen_s, in_seq_s;
  logic                  ok;
  logic                  adv;
  logic [ROUND_W:0]      adv_from;
  logic [COUNT_W-1:0]    lim, cnt_inc;
  logic signed [FLAG_W:0] pflag_s;
  logic [RW-1:0]         my_rank_ext, extra_rank_ext;
  logic [RANK_BITS-1:0]  round_bit;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign gen_ext  = SW'(in_generation);
  assign pseq_ext = SW'(in_partner_seq);
  assign in_gen_s = gen_ext[SEQ_BITS-1:0];
  assign in_seq_s = pseq_ext[SEQ_BITS-1:0];
  assign pflag_s  = (FLAG_W+1)'(in_partner_flag);

  assign lim     = (poll_limit_r == '0) ? COUNT_W'(1) : poll_limit_r;
  assign cnt_inc = cnt_r + COUNT_W'(1);

  always_comb begin
    phase_nxt = phase_r;
    round_nxt = round_r;
    gen_nxt   = gen_r;
    flag_nxt  = flag_r;
    cnt_nxt   = cnt_r;
    yield_nxt = 1'b0;
    adv       = 1'b0;
    adv_from  = '0;
    ok        = 1'b0;

    if (in_kind == KIND_START) begin
      gen_nxt   = in_gen_s;
      flag_nxt  = FLAG_ARRIVED;
      cnt_nxt   = '0;
      round_nxt = '0;
      if (node_role_r == ROLE_EXCH_EXTRA) begin
        phase_nxt = PH_PRE;
      end else begin
        adv = 1'b1;
      end
    end else if (phase_r == PH_PRE || phase_r == PH_EXCH || phase_r == PH_POST) begin
      case (phase_r)
        PH_PRE: begin
          ok = (in_seq_s >= gen_r);
        end
        PH_EXCH: begin
          ok = (in_seq_s > gen_r) ||
               ((in_seq_s == gen_r) && (pflag_s >= $signed({2'b00, round_r})));
        end
        default: begin
          ok = (in_seq_s > gen_r) ||
               ((in_seq_s == gen_r) && (pflag_s == $signed({2'b00, final_flag_r})));
        end
      endcase
      if (ok) begin
        case (phase_r)
          PH_PRE: begin
            adv = 1'b1;
          end
          PH_EXCH: begin
            adv      = 1'b1;
            adv_from = {1'b0, round_r} + (ROUND_W+1)'(1);
          end
          default: begin
            cnt_nxt   = '0;
            phase_nxt = PH_DONE;
          end
        endcase
      end else begin
        // count the failed poll; yield at the limit or on wrap
        cnt_nxt = cnt_inc;
        if (cnt_inc >= lim || cnt_inc == '0) begin
          yield_nxt = 1'b1;
          cnt_nxt   = '0;
        end
      end
    end

    if (adv) begin
      cnt_nxt = '0;
      if (adv_from < {1'b0, exch_count_r}) begin
        phase_nxt = PH_EXCH;
        round_nxt = adv_from[ROUND_W-1:0];
        flag_nxt  = adv_from;
      end else if (node_role_r == ROLE_EXTRA) begin
        phase_nxt = PH_POST;
      end else begin
        if (node_role_r == ROLE_EXCH_EXTRA) begin
          flag_nxt = {1'b0, exch_count_r};
        end
        phase_nxt = PH_DONE;
      end
    end
  end

  // Next rank to poll, reduced to RANK_BITS
  assign my_rank_ext    = RW'(my_rank_r);
  assign extra_rank_ext = RW'(extra_rank_r);
  assign round_bit      = {{(RANK_BITS-1){1'b0}}, 1'b1} << round_nxt;

  always_comb begin
    case (phase_nxt)
      PH_PRE, PH_POST: rank_nxt = extra_rank_ext[RANK_BITS-1:0];
      PH_EXCH:         rank_nxt = my_rank_ext[RANK_BITS-1:0] ^ round_bit;
      default:         rank_nxt = '0;
    endcase
  end

  assign gen_out_ext = SW'(gen_nxt);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      my_rank_r    <= '0;
      node_role_r  <= '0;
      extra_rank_r <= '0;
      exch_count_r <= '0;
      final_flag_r <= '0;
      poll_limit_r <= COUNT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MY_RANK:        my_rank_r    <= cfg_wdata[CFG_RANK_W-1:0];
        REG_NODE_ROLE:      node_role_r  <= cfg_wdata[ROLE_W-1:0];
        REG_EXTRA_RANK:     extra_rank_r <= cfg_wdata[CFG_RANK_W-1:0];
        REG_EXCHANGE_COUNT: exch_count_r <= cfg_wdata[ROUND_W-1:0];
        REG_FINAL_FLAG:     final_flag_r <= cfg_wdata[ROUND_W-1:0];
        REG_POLL_LIMIT:     poll_limit_r <= cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Engine state advances on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_INACTIVE;
      round_r <= '0;
      gen_r   <= '0;
      flag_r  <= '0;
      cnt_r   <= '0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      round_r <= round_nxt;
      gen_r   <= gen_nxt;
      flag_r  <= flag_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Result register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_phase_r <= phase_nxt;
      out_rank_r  <= rank_nxt;
      out_flag_r  <= flag_nxt;
      out_seq_r   <= gen_out_ext[WORD_W-1:0];
      out_done_r  <= (phase_nxt == PH_DONE);
      out_yield_r <= yield_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_phase     = out_phase_r;
  assign out_poll_rank = out_rank_r;
  assign out_my_flag   = out_flag_r;
  assign out_my_seq    = out_seq_r;
  assign out_done_res  = out_done_r;
  assign out_yielded   = out_yield_r;

endmodule

`default_nettype wire
